// ===== sv/nfpe_pkg.sv =====
// Shared types and codes for the NOR flash program/erase planner.
// Holds item structs, command/status/opcode codes and default geometry.
// No dependencies.
package nfpe_pkg;

    // Default flash geometry (bytes, powers of two)
    localparam int unsigned FLASH_BYTES_DEF  = 8388608;
    localparam int unsigned PAGE_BYTES_DEF   = 256;
    localparam int unsigned SECTOR_BYTES_DEF = 4096;
    localparam int unsigned BLOCK_BYTES_DEF  = 65536;

    // Request commands
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_ERASE = 2'd1;
    localparam logic [1:0] CMD_NEXT  = 2'd2;

    // Result status
    localparam logic [1:0] STS_ISSUED = 2'd0;
    localparam logic [1:0] STS_NONE   = 2'd1;
    localparam logic [1:0] STS_ERROR  = 2'd2;

    // Flash command bytes
    localparam logic [7:0] OP_NONE         = 8'h00;
    localparam logic [7:0] OP_PROGRAM      = 8'h02;
    localparam logic [7:0] OP_SECTOR_ERASE = 8'h20;
    localparam logic [7:0] OP_BLOCK_ERASE  = 8'hD8;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WRITE,
        MODE_ERASE
    } plan_mode_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] start_address;
        logic [31:0] byte_count;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  opcode;
        logic [22:0] op_address;
        logic [8:0]  op_length;
        logic [22:0] buffer_offset;
        logic        last;
    } rsp_item_t;

endpackage

// ===== sv/nfpe_step.sv =====
// One planning step: decodes a request against the current plan state and
// produces the result item and the next plan state. Pure combinational.
// Depends on nfpe_pkg.
module nfpe_step #(
    parameter int unsigned FLASH_BYTES  = nfpe_pkg::FLASH_BYTES_DEF,
    parameter int unsigned PAGE_BYTES   = nfpe_pkg::PAGE_BYTES_DEF,
    parameter int unsigned SECTOR_BYTES = nfpe_pkg::SECTOR_BYTES_DEF,
    parameter int unsigned BLOCK_BYTES  = nfpe_pkg::BLOCK_BYTES_DEF,
    parameter int unsigned ADDR_W       = $clog2(FLASH_BYTES) + 1
) (
    input  nfpe_pkg::req_item_t  req,
    input  nfpe_pkg::plan_mode_t mode,
    input  logic [ADDR_W-1:0]    cursor,
    input  logic [ADDR_W-1:0]    end_addr,
    input  logic [ADDR_W-1:0]    offset,
    output nfpe_pkg::rsp_item_t  rsp,
    output nfpe_pkg::plan_mode_t mode_next,
    output logic [ADDR_W-1:0]    cursor_next,
    output logic [ADDR_W-1:0]    end_next,
    output logic [ADDR_W-1:0]    offset_next
);

    localparam int unsigned PAGE_LOG = $clog2(PAGE_BYTES);
    localparam int unsigned CHUNK_W  = PAGE_LOG + 1;

    logic [32:0]          wr_sum;
    logic [31:0]          er_base;
    logic [32:0]          er_sum;
    logic [32:0]          er_end;
    logic                 emit;
    logic [1:0]           early_status;
    nfpe_pkg::plan_mode_t w_mode;
    logic [ADDR_W-1:0]    w_cur;
    logic [ADDR_W-1:0]    w_end;
    logic [ADDR_W-1:0]    w_off;
    logic [ADDR_W-1:0]    remain;
    logic [CHUNK_W-1:0]   page_room;
    logic [ADDR_W-1:0]    chunk;
    logic                 use_block;
    logic [ADDR_W-1:0]    new_cur;
    logic                 fin;

    // Bounds sums at full width so nothing wraps
    assign wr_sum  = {1'b0, req.start_address} + {1'b0, req.byte_count};
    assign er_base = req.start_address & ~(32'(SECTOR_BYTES) - 32'd1);
    assign er_sum  = {1'b0, er_base} + {1'b0, req.byte_count};
    assign er_end  = (er_sum + 33'(SECTOR_BYTES - 1)) & ~33'(SECTOR_BYTES - 1);

    // Request decode: start a new plan or continue the running one
    always_comb
    begin
        emit         = 1'b0;
        early_status = nfpe_pkg::STS_NONE;
        w_mode       = nfpe_pkg::MODE_IDLE;
        w_cur        = cursor;
        w_end        = end_addr;
        w_off        = offset;
        case (req.command)
            nfpe_pkg::CMD_WRITE:
            begin
                if (wr_sum > 33'(FLASH_BYTES))
                begin
                    early_status = nfpe_pkg::STS_ERROR;
                end
                else if (req.byte_count != 32'd0)
                begin
                    emit   = 1'b1;
                    w_mode = nfpe_pkg::MODE_WRITE;
                    w_cur  = req.start_address[ADDR_W-1:0];
                    w_end  = wr_sum[ADDR_W-1:0];
                    w_off  = '0;
                end
            end
            nfpe_pkg::CMD_ERASE:
            begin
                // zero length wins over the range check here
                if (req.byte_count == 32'd0)
                begin
                    early_status = nfpe_pkg::STS_NONE;
                end
                else if (er_sum > 33'(FLASH_BYTES))
                begin
                    early_status = nfpe_pkg::STS_ERROR;
                end
                else
                begin
                    emit   = 1'b1;
                    w_mode = nfpe_pkg::MODE_ERASE;
                    w_cur  = er_base[ADDR_W-1:0];
                    w_end  = er_end[ADDR_W-1:0];
                    w_off  = '0;
                end
            end
            default:
            begin
                // next, and the unused code, continue the plan
                emit   = 1'b1;
                w_mode = mode;
            end
        endcase
    end

    // Page chunk and erase size from the working cursor
    assign remain    = w_end - w_cur;
    assign page_room = CHUNK_W'(PAGE_BYTES) - CHUNK_W'(w_cur[PAGE_LOG-1:0]);
    assign chunk     = (ADDR_W'(page_room) > remain) ? remain : ADDR_W'(page_room);
    assign use_block = ((w_cur & ADDR_W'(BLOCK_BYTES - 1)) == '0)
                       && (33'(remain) >= 33'(BLOCK_BYTES));

    // Emit one operation, or a no-op or error result
    always_comb
    begin
        rsp         = '0;
        rsp.status  = early_status;
        rsp.last    = 1'b1;
        mode_next   = nfpe_pkg::MODE_IDLE;
        cursor_next = cursor;
        end_next    = end_addr;
        offset_next = offset;
        new_cur     = w_cur;
        fin         = 1'b1;
        if (emit && (w_cur < w_end) && (w_mode != nfpe_pkg::MODE_IDLE))
        begin
            rsp.status     = nfpe_pkg::STS_ISSUED;
            rsp.op_address = w_cur[22:0];
            if (w_mode == nfpe_pkg::MODE_WRITE)
            begin
                new_cur           = w_cur + chunk;
                rsp.opcode        = nfpe_pkg::OP_PROGRAM;
                rsp.op_length     = 9'(chunk);
                rsp.buffer_offset = w_off[22:0];
                offset_next       = w_off + chunk;
            end
            else
            begin
                if (use_block)
                begin
                    new_cur    = w_cur + ADDR_W'(BLOCK_BYTES);
                    rsp.opcode = nfpe_pkg::OP_BLOCK_ERASE;
                end
                else
                begin
                    new_cur    = w_cur + ADDR_W'(SECTOR_BYTES);
                    rsp.opcode = nfpe_pkg::OP_SECTOR_ERASE;
                end
                offset_next = w_off;
            end
            fin         = (new_cur >= w_end);
            rsp.last    = fin;
            mode_next   = fin ? nfpe_pkg::MODE_IDLE : w_mode;
            cursor_next = new_cur;
            end_next    = w_end;
        end
        else if (emit)
        begin
            rsp.status = nfpe_pkg::STS_NONE;
        end
    end

endmodule

// ===== sv/nor_flash_program_erase_planner_core.sv =====
// Top level of the NOR flash program/erase planner: request register,
// plan state registers and result register around one step of logic.
// Depends on nfpe_pkg and nfpe_step.
//
// Each request item yields exactly one result item. A write command starts a
// plan of page-program chunks that never cross a page; an erase command starts
// a plan of block or sector erases covering the request widened to sectors;
// a next command pulls the following operation, and the last one is flagged.
// A request goes through the request register, then the step logic into the
// result register; one item is taken every cycle unless the result side stalls:
// the step reads and updates the plan registers in the same cycle, so
// consecutive items need no spacing. Result back-pressure holds the pipeline;
// the request side stalls only when both stages are full and rsp_stall is high.
module nor_flash_program_erase_planner_core #(
    parameter int unsigned FLASH_BYTES  = nfpe_pkg::FLASH_BYTES_DEF,
    parameter int unsigned PAGE_BYTES   = nfpe_pkg::PAGE_BYTES_DEF,
    parameter int unsigned SECTOR_BYTES = nfpe_pkg::SECTOR_BYTES_DEF,
    parameter int unsigned BLOCK_BYTES  = nfpe_pkg::BLOCK_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  nfpe_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output nfpe_pkg::rsp_item_t rsp
);

    localparam int unsigned ADDR_W = $clog2(FLASH_BYTES) + 1;

    logic                 hold_valid_reg;
    nfpe_pkg::req_item_t  hold_reg;
    logic                 rsp_valid_reg;
    nfpe_pkg::rsp_item_t  rsp_reg;
    nfpe_pkg::plan_mode_t mode_reg;
    logic [ADDR_W-1:0]    cursor_reg;
    logic [ADDR_W-1:0]    end_reg;
    logic [ADDR_W-1:0]    offset_reg;

    nfpe_pkg::rsp_item_t  rsp_next;
    nfpe_pkg::plan_mode_t mode_next;
    logic [ADDR_W-1:0]    cursor_next;
    logic [ADDR_W-1:0]    end_next;
    logic [ADDR_W-1:0]    offset_next;
    logic                 advance;
    logic                 load_hold;

    // Result slot free or being drained this cycle
    assign advance   = !rsp_valid_reg || !rsp_stall;
    // Request register takes an item when empty or moving on
    assign load_hold = advance || !hold_valid_reg;
    assign req_stall = hold_valid_reg && !advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    nfpe_step #(
        .FLASH_BYTES  (FLASH_BYTES),
        .PAGE_BYTES   (PAGE_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES),
        .BLOCK_BYTES  (BLOCK_BYTES),
        .ADDR_W       (ADDR_W)
    ) u_step (
        .req         (hold_reg),
        .mode        (mode_reg),
        .cursor      (cursor_reg),
        .end_addr    (end_reg),
        .offset      (offset_reg),
        .rsp         (rsp_next),
        .mode_next   (mode_next),
        .cursor_next (cursor_next),
        .end_next    (end_next),
        .offset_next (offset_next)
    );

    // Control: stage valids and plan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            mode_reg       <= nfpe_pkg::MODE_IDLE;
            cursor_reg     <= '0;
            end_reg        <= '0;
            offset_reg     <= '0;
        end
        else
        begin
            if (load_hold)
            begin
                hold_valid_reg <= req_valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= hold_valid_reg;
                if (hold_valid_reg)
                begin
                    mode_reg   <= mode_next;
                    cursor_reg <= cursor_next;
                    end_reg    <= end_next;
                    offset_reg <= offset_next;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (load_hold)
        begin
            hold_reg <= req;
        end
        if (advance && hold_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule
